### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg) \
  `ASSERT_PROP(lbl, clk_s, rst_s, !(expr), msg)

`endif

### src/fwna_pkg.sv
// ---------------------------------------------------------------------------
// fwna_pkg
// Shared types, ASCII codes and elaboration helpers for the number formatter.
// ---------------------------------------------------------------------------
`default_nettype none

package fwna_pkg;

  localparam int NUMBER_WIDTH_DEF = 32;

  localparam logic [6:0] ASC_ZERO  = 7'h30;
  localparam logic [6:0] ASC_A     = 7'h41;
  localparam logic [6:0] ASC_PLUS  = 7'h2B;
  localparam logic [6:0] ASC_MINUS = 7'h2D;

  typedef enum logic [1:0] {
    MODE_UDEC = 2'd0,
    MODE_SDEC = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_BIN  = 2'd3
  } mode_t;

  // decimal digits of the largest w-bit value
  function automatic int dec_digits(int w);
    logic [71:0] p;
    logic [71:0] m;
    int          n;
    m = (72'd1 << w) - 72'd1;
    p = 72'd1;
    n = 0;
    for (int k = 0; k < 24; k++) begin
      if (p <= m) begin
        p = p * 72'd10;
        n = n + 1;
      end
    end
    return n;
  endfunction

  // digit counts never pass 63
  function automatic int sat63(int x);
    return (x > 63) ? 63 : x;
  endfunction

endpackage

`default_nettype wire

### src/fixed_width_number_to_ascii.sv
// ---------------------------------------------------------------------------
// fixed_width_number_to_ascii
// Formats one number as a row of fixed-width ASCII characters.
// ---------------------------------------------------------------------------
// Usage:
//  - Input word on s_*: s_tuser holds the mode (unsigned decimal, signed
//    decimal, hex, binary); s_tdata holds number, digit count, line, column.
//  - One output word per character on m_*, most significant digit first,
//    signed decimal preceded by '+' or '-'; m_tlast marks the final one.
//  - Digit count saturates per mode (decimal digits of the widest value,
//    NUMBER_WIDTH/4 rounded up for hex, NUMBER_WIDTH for binary, at most 63).
//  - Order: hex and binary go from accept straight to character emission.
//    Decimal runs a bit-serial BCD conversion first, one shift per bit of
//    NUMBER_WIDTH, then emits its characters.
//  - s_tready is high only while no number is in work; the last character may
//    still sit in the output register while the next number is taken.
//  - A stalled receiver (m_tready low) freezes character emission; nothing is
//    dropped. An unsigned request with zero digits emits nothing.
//  - rst (synchronous, active high) drops any number in work and empties the
//    output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fixed_width_number_to_ascii #(
  parameter int NUMBER_WIDTH = fwna_pkg::NUMBER_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // number[31:0], digit_count[37:32],
                                      // text_line[40:38], start_column[45:41]
  input  wire logic [1:0]  s_tuser,   // req_type[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // line_out[2:0], column_out[8:3],
                                      // char_code[15:9]
  output logic             m_tlast    // last_char
);

  localparam int DEC_DIGITS = fwna_pkg::dec_digits(NUMBER_WIDTH);
  localparam logic [5:0] LIM_DEC = 6'(fwna_pkg::sat63(DEC_DIGITS));
  localparam logic [5:0] LIM_HEX = 6'(fwna_pkg::sat63((NUMBER_WIDTH + 3) / 4));
  localparam logic [5:0] LIM_BIN = 6'(fwna_pkg::sat63(NUMBER_WIDTH));

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // input fields
  fwna_pkg::mode_t          in_mode;
  logic [31:0]              in_number;
  logic [5:0]               in_count;
  logic [2:0]               in_line;
  logic [4:0]               in_col;

  assign in_mode   = fwna_pkg::mode_t'(s_tuser);
  assign in_number = s_tdata[31:0];
  assign in_count  = s_tdata[37:32];
  assign in_line   = s_tdata[40:38];
  assign in_col    = s_tdata[45:41];

  state_t                   state;
  state_t                   state_next;
  fwna_pkg::mode_t          mode_q;
  logic [NUMBER_WIDTH-1:0]  val_q;
  logic                     neg_q;
  logic                     len_zero_q;
  logic                     sign_pending;
  logic [5:0]               pos;
  logic [2:0]               line_q;
  logic [5:0]               col_q;

  logic [2:0]               out_line;
  logic [5:0]               out_col;
  logic [6:0]               out_code;

  logic                     accept;
  logic                     load;
  logic                     load_last;
  logic [5:0]               lim;
  logic [5:0]               len_sat;
  logic [NUMBER_WIDTH-1:0]  v_in;
  logic [NUMBER_WIDTH-1:0]  v_neg;
  logic                     v_is_neg;
  logic [NUMBER_WIDTH-1:0]  v_mag;
  logic                     is_dec;

  logic                     dab_busy;
  logic [4*DEC_DIGITS-1:0]  dab_bcd;
  logic [6:0]               enc_code;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load     = (state == ST_EMIT) && (!m_tvalid || m_tready);
  // final character: sign with no digits, or the lowest digit
  assign load_last = load && (sign_pending ? (pos == 6'd0 && len_zero_q) : (pos == 6'd0));

  // digit limit for the requested mode
  always_comb begin
    unique case (in_mode)
      fwna_pkg::MODE_HEX: lim = LIM_HEX;
      fwna_pkg::MODE_BIN: lim = LIM_BIN;
      default:            lim = LIM_DEC;
    endcase
  end

  assign len_sat  = (in_count > lim) ? lim : in_count;
  assign is_dec   = (in_mode == fwna_pkg::MODE_UDEC) || (in_mode == fwna_pkg::MODE_SDEC);

  // value reduced to NUMBER_WIDTH bits; magnitude taken in signed mode
  assign v_in     = NUMBER_WIDTH'(in_number);
  assign v_neg    = ~v_in + {{(NUMBER_WIDTH-1){1'b0}}, 1'b1};
  assign v_is_neg = (in_mode == fwna_pkg::MODE_SDEC) && v_in[NUMBER_WIDTH-1];
  assign v_mag    = v_is_neg ? v_neg : v_in;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == fwna_pkg::MODE_SDEC) begin
            state_next = ST_CONV;
          end else if (len_sat == 6'd0) begin
            state_next = ST_IDLE;
          end else if (is_dec) begin
            state_next = ST_CONV;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        if (!dab_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sign_pending <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        sign_pending <= (in_mode == fwna_pkg::MODE_SDEC);
      end else if (load) begin
        sign_pending <= 1'b0;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item context and character position
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q     <= in_mode;
      val_q      <= v_mag;
      neg_q      <= v_is_neg;
      len_zero_q <= (len_sat == 6'd0);
      pos        <= (len_sat == 6'd0) ? 6'd0 : len_sat - 6'd1;
      line_q     <= in_line;
      col_q      <= {1'b0, in_col};
    end else if (load) begin
      col_q <= col_q + 6'd1;
      if (!sign_pending && pos != 6'd0) begin
        pos <= pos - 6'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_line <= line_q;
      out_col  <= col_q;
      out_code <= enc_code;
      m_tlast  <= load_last;
    end
  end

  assign m_tdata = {out_code, out_col, out_line};

  // conversion runs only for words that go on to the conversion state
  fwna_dabble #(
    .NUMBER_WIDTH (NUMBER_WIDTH),
    .DEC_DIGITS   (DEC_DIGITS)
  ) u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (accept && (state_next == ST_CONV)),
    .value (v_mag),
    .busy  (dab_busy),
    .bcd   (dab_bcd)
  );

  fwna_char_enc #(
    .NUMBER_WIDTH (NUMBER_WIDTH),
    .DEC_DIGITS   (DEC_DIGITS)
  ) u_char_enc (
    .mode     (mode_q),
    .val      (val_q),
    .bcd      (dab_bcd),
    .pos      (pos),
    .sign_sel (sign_pending),
    .neg      (neg_q),
    .code     (enc_code)
  );

  `ASSERT_PROP(a_last_idle, clk, rst, load_last |=> (state == ST_IDLE), "no idle after last char")
  `ASSERT_NEVER(a_conv_quiet, clk, rst, (state == ST_CONV) && load, "char emitted mid conversion")
  `ASSERT_NEVER(a_emit_done, clk, rst, (state == ST_EMIT) && dab_busy, "emit before BCD ready")

endmodule

`default_nettype wire

### src/fwna_dabble.sv
// ---------------------------------------------------------------------------
// fwna_dabble
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fwna_dabble #(
  parameter int NUMBER_WIDTH = fwna_pkg::NUMBER_WIDTH_DEF,
  parameter int DEC_DIGITS   = fwna_pkg::dec_digits(fwna_pkg::NUMBER_WIDTH_DEF)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [NUMBER_WIDTH-1:0]   value,
  output logic                           busy,
  output logic [4*DEC_DIGITS-1:0]        bcd
);

  localparam int BW   = 4 * DEC_DIGITS;
  localparam int CNTW = $clog2(NUMBER_WIDTH);

  logic [NUMBER_WIDTH-1:0] sh;
  logic [CNTW-1:0]         cnt;
  logic [BW-1:0]           adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < DEC_DIGITS; k++) begin
      adj[4*k +: 4] = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3 : bcd[4*k +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNTW'(NUMBER_WIDTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= value;
      bcd <= '0;
    end else if (busy) begin
      sh  <= {sh[NUMBER_WIDTH-2:0], 1'b0};
      bcd <= {adj[BW-2:0], sh[NUMBER_WIDTH-1]};
    end
  end

  `ASSERT_PROP(a_start_busy, clk, rst, start |=> busy, "conversion did not start")

endmodule

`default_nettype wire

### src/fwna_char_enc.sv
// ---------------------------------------------------------------------------
// fwna_char_enc
// Picks the digit at one position for the mode and maps it to ASCII.
// ---------------------------------------------------------------------------
`default_nettype none

module fwna_char_enc #(
  parameter int NUMBER_WIDTH = fwna_pkg::NUMBER_WIDTH_DEF,
  parameter int DEC_DIGITS   = fwna_pkg::dec_digits(fwna_pkg::NUMBER_WIDTH_DEF)
) (
  input  wire fwna_pkg::mode_t           mode,
  input  wire logic [NUMBER_WIDTH-1:0]   val,
  input  wire logic [4*DEC_DIGITS-1:0]   bcd,
  input  wire logic [5:0]                pos,
  input  wire logic                      sign_sel,
  input  wire logic                      neg,
  output logic [6:0]                     code
);

  logic [NUMBER_WIDTH-1:0]   hsh;
  logic [NUMBER_WIDTH-1:0]   bsh;
  logic [4*DEC_DIGITS-1:0]   dsh;
  logic [3:0]                dig;

  assign hsh = val >> {pos, 2'b00};
  assign bsh = val >> pos;
  assign dsh = bcd >> {pos, 2'b00};

  always_comb begin
    unique case (mode)
      fwna_pkg::MODE_HEX: dig = hsh[3:0];
      fwna_pkg::MODE_BIN: dig = {3'b000, bsh[0]};
      default:            dig = dsh[3:0];
    endcase
  end

  always_comb begin
    if (sign_sel) begin
      code = neg ? fwna_pkg::ASC_MINUS : fwna_pkg::ASC_PLUS;
    end else if (dig < 4'd10) begin
      code = fwna_pkg::ASC_ZERO + {3'b000, dig};
    end else begin
      code = fwna_pkg::ASC_A - 7'd10 + {3'b000, dig};
    end
  end

endmodule

`default_nettype wire
